### rtl/axis_expectation_reducer_top_defines.svh
// Assertion macros for the axis expectation reducer.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef AXIS_EXPECTATION_REDUCER_TOP_DEFINES_SVH
`define AXIS_EXPECTATION_REDUCER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// pre holds in a cycle -> post holds in the same cycle
`define AER_ASSERT_IMPL(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("axis expectation reducer check failed");
// pre holds in a cycle -> post holds in the next cycle
`define AER_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("axis expectation reducer check failed");
`else
`define AER_ASSERT_IMPL(lbl, clk, rst, pre, post)
`define AER_ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif
`endif

### rtl/aer_pkg.sv
// Shared constants for the axis expectation reducer: field widths,
// register map, reset values and parameter defaults. No dependencies.
`default_nettype none

package aer_pkg;

   // parameter defaults (plane depth is a power of two)
   localparam int AER_MAX_DIM     = 64;
   localparam int AER_PLANE_CELLS = 4096;

   // field widths
   localparam int PROB_W     = 17;
   localparam int CELL_IDX_W = 12;
   localparam int SUM_W      = 40;
   localparam int BOUND_W    = 16;
   localparam int SIZE_W     = 7;
   localparam int AXIS_W     = 2;

   // fraction bits between Q8.8 bounds and Q.24 positions, and Q1.16 prob
   localparam int FRAC_W = 16;

   // register port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] REG_REDUCE_AXIS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RANGE_LOW   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RANGE_HIGH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DEPTH_SIZE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ROW_SIZE    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_COL_SIZE    = 3'd5;

   // axis codes; anything else collapses the column axis
   localparam logic [AXIS_W-1:0] AXIS_DEPTH = 2'd0;
   localparam logic [AXIS_W-1:0] AXIS_ROW   = 2'd1;

   // reset values
   localparam logic [AXIS_W-1:0]         AXIS_RST       = AXIS_DEPTH;
   localparam logic signed [BOUND_W-1:0] RANGE_LOW_RST  = 16'sd0;
   localparam logic signed [BOUND_W-1:0] RANGE_HIGH_RST = 16'sd256;
   localparam logic [SIZE_W-1:0]         SIZE_RST       = 7'd64;

endpackage

`default_nettype wire

### rtl/aer_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// Holds the plane partial sums; no dependencies.
`default_nettype none

module aer_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/axis_expectation_reducer_top.sv
// Channel     | Direction | Handshake            | Payload
// ------------+-----------+----------------------+-------------------------------------
// request     | in        | req_valid/req_ready  | req_prob (Q1.16)
// response    | out       | rsp_valid/rsp_ready  | rsp_cell_index, rsp_sum_value,
//             |           |                      | rsp_volume_done
// registers   | in/out    | APB psel/penable     | paddr, pwdata, prdata
//
// One sample at a time, a new one taken only once the last is through: an accept step,
// the bit-serial divider that forms the bin centre, then position, two partial-product
// steps, rounding, and the partial-sum read-modify-write.
// Reset clears counters, CSRs, rsp_valid and the FSM; the partial-sum RAM is not cleared.
// A completed cell sits in the output register while the next sample is taken;
// only a second completion with that register still full stalls in the write-back step.
// Depends on aer_pkg, aer_ram and axis_expectation_reducer_top_defines.svh.
`default_nettype none
`include "axis_expectation_reducer_top_defines.svh"

module axis_expectation_reducer_top
   import aer_pkg::*;
#(
   parameter int MAX_DIM     = AER_MAX_DIM,
   parameter int PLANE_CELLS = AER_PLANE_CELLS
) (
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [PROB_W-1:0]       req_prob,
   // response channel
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [CELL_IDX_W-1:0]   rsp_cell_index,
   output logic signed [SUM_W-1:0] rsp_sum_value,
   output logic                    rsp_volume_done,
   // register port
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [CSR_ADDR_W-1:0]   paddr,
   input  logic [CSR_DATA_W-1:0]   pwdata,
   output logic [CSR_DATA_W-1:0]   prdata,
   output logic                    pready
);

   // derived widths
   localparam int CW     = $clog2(MAX_DIM);          // counter
   localparam int NW     = $clog2(MAX_DIM + 1);      // effective size
   localparam int DW     = NW + 1;                   // divisor 2n
   localparam int AW     = BOUND_W + CW + 1;         // |diff| * (2i+1)
   localparam int NUM_W  = AW + FRAC_W;              // dividend and quotient
   localparam int DCW    = $clog2(NUM_W);
   localparam int PW     = NUM_W + 2;                // position, Q.24
   localparam int LO_W   = PW / 2;
   localparam int HI_W   = PW - LO_W;
   localparam int PL_W   = PROB_W + LO_W;
   localparam int PH_W   = PROB_W + 1 + HI_W;
   localparam int RW     = PL_W > PH_W + LO_W ? PL_W + 1 : PH_W + LO_W;
   localparam int TW     = RW - FRAC_W;              // rounded term
   localparam int XW     = (TW > SUM_W ? TW : SUM_W) + 1;
   localparam int CELL_W = $clog2(PLANE_CELLS);
   localparam int CR_W   = CW + NW + 1;
   localparam int RAW_W  = CR_W > CELL_W ? CR_W : CELL_W;

   localparam logic [DCW-1:0] DIV_LAST   = DCW'(NUM_W - 1);
   localparam logic [RW-1:0]  ROUND_HALF = RW'(1) << (FRAC_W - 1);
   localparam logic [SUM_W-1:0] SUM_MAX  = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic [SUM_W-1:0] SUM_MIN  = {1'b1, {(SUM_W-1){1'b0}}};

   // sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DIV    = 3'd1;
   localparam logic [2:0] ST_POS    = 3'd2;
   localparam logic [2:0] ST_MUL_LO = 3'd3;
   localparam logic [2:0] ST_MUL_HI = 3'd4;
   localparam logic [2:0] ST_TERM   = 3'd5;
   localparam logic [2:0] ST_ACC    = 3'd6;

   // size 0 reads as 1, sizes above MAX_DIM read as MAX_DIM
   function automatic logic [NW-1:0] eff_size(input logic [SIZE_W-1:0] v);
      logic [NW-1:0] res;
      if (v == '0) begin
         res = NW'(1);
      end else if (int'(v) > MAX_DIM) begin
         res = NW'(MAX_DIM);
      end else begin
         res = NW'(v);
      end
      return res;
   endfunction

   // configuration registers
   logic [AXIS_W-1:0]         axis_ff;
   logic signed [BOUND_W-1:0] range_low_ff;
   logic signed [BOUND_W-1:0] range_high_ff;
   logic [SIZE_W-1:0]         depth_size_ff;
   logic [SIZE_W-1:0]         row_size_ff;
   logic [SIZE_W-1:0]         col_size_ff;
   logic                      csr_wr;
   logic [CSR_IDX_W-1:0]      csr_idx;

   // control state
   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] d_ff, d_in, r_ff, r_in, c_ff, c_in;
   logic [DCW-1:0] div_cnt_ff, div_cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // per-sample payload
   logic [PROB_W-1:0]       prob_ff, prob_in;
   logic [NUM_W-1:0]        num_ff, num_in;
   logic [DW-1:0]           rem_ff, rem_in;
   logic [DW-1:0]           divisor_ff, divisor_in;
   logic                    neg_ff, neg_in;
   logic [CELL_W-1:0]       cell_ff, cell_in;
   logic                    first_ff, first_in;
   logic                    last_ff, last_in;
   logic                    done_ff, done_in;
   logic signed [PW-1:0]    pos_ff, pos_in;
   logic [PL_W-1:0]         plo_ff, plo_in;
   logic signed [PH_W-1:0]  phi_ff, phi_in;
   logic signed [TW-1:0]    term_ff, term_in;
   logic [CELL_IDX_W-1:0]   rsp_cell_ff, rsp_cell_in;
   logic [SUM_W-1:0]        rsp_sum_ff, rsp_sum_in;
   logic                    rsp_done_ff, rsp_done_in;

   // accept-time decode
   logic [NW-1:0]          nd, nr, nc, n_sel;
   logic                   last_d, last_r, last_c;
   logic [CW-1:0]          bin, cell_a, cell_c;
   logic [NW-1:0]          cell_b;
   logic                   first_sel, last_sel;
   logic signed [BOUND_W:0] diff;
   logic [BOUND_W:0]       diff_mag;
   logic [AW-1:0]          a_prod;
   logic [RAW_W-1:0]       cell_raw;

   // divider step
   logic [DW:0]   rem_sh, div_diff;
   logic          div_ge;
   logic [DW-1:0] div_rem;

   // position, rounding and accumulation
   logic signed [PW-1:0]   lo_sh, q_s, pos_calc;
   logic signed [PROB_W:0] p_s;
   logic signed [HI_W-1:0] h_s;
   logic [RW-1:0]          prod_sum;
   logic signed [XW-1:0]   acc_x;
   logic [XW-SUM_W:0]      acc_top;
   logic [SUM_W-1:0]       acc_sat;
   logic                   out_free, acc_go;
   logic [CELL_W+CELL_IDX_W-1:0] cell_ext;

   // partial-sum memory
   logic             mem_wr_en, mem_rd_en;
   logic [SUM_W-1:0] mem_rd_data;

   // register port
   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = paddr[CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff       <= AXIS_RST;
         range_low_ff  <= RANGE_LOW_RST;
         range_high_ff <= RANGE_HIGH_RST;
         depth_size_ff <= SIZE_RST;
         row_size_ff   <= SIZE_RST;
         col_size_ff   <= SIZE_RST;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_REDUCE_AXIS: axis_ff       <= pwdata[AXIS_W-1:0];
            REG_RANGE_LOW:   range_low_ff  <= pwdata[BOUND_W-1:0];
            REG_RANGE_HIGH:  range_high_ff <= pwdata[BOUND_W-1:0];
            REG_DEPTH_SIZE:  depth_size_ff <= pwdata[SIZE_W-1:0];
            REG_ROW_SIZE:    row_size_ff   <= pwdata[SIZE_W-1:0];
            REG_COL_SIZE:    col_size_ff   <= pwdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_REDUCE_AXIS: prdata = {{(CSR_DATA_W-AXIS_W){1'b0}}, axis_ff};
         REG_RANGE_LOW:   prdata = {{(CSR_DATA_W-BOUND_W){1'b0}}, range_low_ff};
         REG_RANGE_HIGH:  prdata = {{(CSR_DATA_W-BOUND_W){1'b0}}, range_high_ff};
         REG_DEPTH_SIZE:  prdata = {{(CSR_DATA_W-SIZE_W){1'b0}}, depth_size_ff};
         REG_ROW_SIZE:    prdata = {{(CSR_DATA_W-SIZE_W){1'b0}}, row_size_ff};
         REG_COL_SIZE:    prdata = {{(CSR_DATA_W-SIZE_W){1'b0}}, col_size_ff};
         default:         prdata = '0;
      endcase
   end

   // sample decode: last flags, collapsed bin, range difference, dividend and plane cell operands
   always_comb begin
      nd = eff_size(depth_size_ff);
      nr = eff_size(row_size_ff);
      nc = eff_size(col_size_ff);
      last_d = (int'(d_ff) + 1) >= int'(nd);
      last_r = (int'(r_ff) + 1) >= int'(nr);
      last_c = (int'(c_ff) + 1) >= int'(nc);
      case (axis_ff)
         AXIS_DEPTH: begin
            bin = d_ff; n_sel = nd; first_sel = (d_ff == '0); last_sel = last_d;
            cell_a = r_ff; cell_b = nc; cell_c = c_ff;
         end
         AXIS_ROW: begin
            bin = r_ff; n_sel = nr; first_sel = (r_ff == '0); last_sel = last_r;
            cell_a = c_ff; cell_b = nd; cell_c = d_ff;
         end
         default: begin
            // column axis, and the unused code
            bin = c_ff; n_sel = nc; first_sel = (c_ff == '0); last_sel = last_c;
            cell_a = r_ff; cell_b = nd; cell_c = d_ff;
         end
      endcase
      diff     = {range_high_ff[BOUND_W-1], range_high_ff}
               - {range_low_ff[BOUND_W-1], range_low_ff};
      diff_mag = diff[BOUND_W] ? -diff : diff;
      a_prod   = AW'(diff_mag[BOUND_W-1:0]) * AW'({bin, 1'b1});
      cell_raw = RAW_W'(cell_a) * RAW_W'(cell_b) + RAW_W'(cell_c);
   end

   // one restoring-division step: quotient bits shift into num_ff
   always_comb begin
      rem_sh   = {rem_ff, num_ff[NUM_W-1]};
      div_diff = rem_sh - {1'b0, divisor_ff};
      div_ge   = rem_sh >= {1'b0, divisor_ff};
      div_rem  = div_ge ? div_diff[DW-1:0] : rem_sh[DW-1:0];
   end

   // bin centre from the rounded quotient, product operands and the rounded product sum
   always_comb begin
      lo_sh    = {{(PW-BOUND_W){range_low_ff[BOUND_W-1]}}, range_low_ff} <<< FRAC_W;
      q_s      = {2'b00, num_ff};
      pos_calc = lo_sh + (neg_ff ? -q_s : q_s);
      p_s      = {1'b0, prob_ff};
      h_s      = pos_ff[PW-1:LO_W];
      prod_sum = (RW'(phi_ff) <<< LO_W) + RW'(plo_ff) + ROUND_HALF;
   end

   // start the sum on the first bin or accumulate, and saturate to the sum range
   always_comb begin
      if (first_ff) begin
         acc_x = XW'(term_ff);
      end else begin
         acc_x = XW'(signed'(mem_rd_data)) + XW'(term_ff);
      end
      acc_top = acc_x[XW-1:SUM_W-1];
      if (acc_top == '0 || acc_top == '1) begin
         acc_sat = acc_x[SUM_W-1:0];
      end else if (acc_x[XW-1]) begin
         acc_sat = SUM_MIN;
      end else begin
         acc_sat = SUM_MAX;
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign acc_go    = !last_ff || out_free;
   assign mem_rd_en = (state_ff == ST_POS);
   assign mem_wr_en = (state_ff == ST_ACC) && acc_go;
   assign cell_ext  = {{CELL_IDX_W{1'b0}}, cell_ff};

   // sequencer
   always_comb begin
      state_in     = state_ff;
      d_in         = d_ff;
      r_in         = r_ff;
      c_in         = c_ff;
      div_cnt_in   = div_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      prob_in      = prob_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      divisor_in   = divisor_ff;
      neg_in       = neg_ff;
      cell_in      = cell_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      done_in      = done_ff;
      pos_in       = pos_ff;
      plo_in       = plo_ff;
      phi_in       = phi_ff;
      term_in      = term_ff;
      rsp_cell_in  = rsp_cell_ff;
      rsp_sum_in   = rsp_sum_ff;
      rsp_done_in  = rsp_done_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               prob_in    = req_prob;
               num_in     = {a_prod, FRAC_W'(n_sel)};  // |diff|(2i+1)*2^16 + n
               rem_in     = '0;
               divisor_in = {n_sel, 1'b0};
               div_cnt_in = '0;
               neg_in     = diff[BOUND_W];
               cell_in    = cell_raw[CELL_W-1:0];
               first_in   = first_sel;
               last_in    = last_sel;
               done_in    = last_d && last_r && last_c;
               // storage-order walk: column fastest
               if (last_c) begin
                  c_in = '0;
                  if (last_r) begin
                     r_in = '0;
                     d_in = last_d ? '0 : d_ff + CW'(1);
                  end else begin
                     r_in = r_ff + CW'(1);
                  end
               end else begin
                  c_in = c_ff + CW'(1);
               end
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            num_in     = {num_ff[NUM_W-2:0], div_ge};
            rem_in     = div_rem;
            div_cnt_in = div_cnt_ff + DCW'(1);
            if (div_cnt_ff == DIV_LAST) begin
               state_in = ST_POS;
            end
         end
         ST_POS: begin
            pos_in   = pos_calc;
            state_in = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            plo_in   = PL_W'(prob_ff) * PL_W'(pos_ff[LO_W-1:0]);
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            phi_in   = PH_W'(p_s) * PH_W'(h_s);
            state_in = ST_TERM;
         end
         ST_TERM: begin
            term_in  = prod_sum[RW-1:FRAC_W];
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (acc_go) begin
               if (last_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_cell_in  = cell_ext[CELL_IDX_W-1:0];
                  rsp_sum_in   = acc_sat;
                  rsp_done_in  = done_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         d_ff         <= '0;
         r_ff         <= '0;
         c_ff         <= '0;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         d_ff         <= d_in;
         r_ff         <= r_in;
         c_ff         <= c_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      prob_ff     <= prob_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      divisor_ff  <= divisor_in;
      neg_ff      <= neg_in;
      cell_ff     <= cell_in;
      first_ff    <= first_in;
      last_ff     <= last_in;
      done_ff     <= done_in;
      pos_ff      <= pos_in;
      plo_ff      <= plo_in;
      phi_ff      <= phi_in;
      term_ff     <= term_in;
      rsp_cell_ff <= rsp_cell_in;
      rsp_sum_ff  <= rsp_sum_in;
      rsp_done_ff <= rsp_done_in;
   end

   // partial sums, one entry per plane cell
   aer_ram #(
      .WIDTH (SUM_W),
      .DEPTH (PLANE_CELLS)
   ) u_sums (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (cell_ff),
      .wr_data (acc_sat),
      .rd_en   (mem_rd_en),
      .rd_addr (cell_ff),
      .rd_data (mem_rd_data)
   );

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cell_index  = rsp_cell_ff;
   assign rsp_sum_value   = rsp_sum_ff;
   assign rsp_volume_done = rsp_done_ff;

   // checks
   `AER_ASSERT_NEXT(a_one_sample_in_flight, clock, reset, req_valid && req_ready, !req_ready)
   `AER_ASSERT_IMPL(a_div_rem_below_divisor, clock, reset, state_ff == ST_DIV, rem_ff < divisor_ff)
   `AER_ASSERT_NEXT(a_read_lines_up_with_mul, clock, reset, mem_rd_en, state_ff == ST_MUL_LO)
   `AER_ASSERT_IMPL(a_rsp_from_last_acc, clock, reset, $rose(rsp_valid_ff), $past(mem_wr_en) && $past(last_ff))
   `AER_ASSERT_NEXT(a_write_ends_sample, clock, reset, mem_wr_en, state_ff == ST_IDLE)

endmodule

`default_nettype wire
